[rtl/point_plane_projection_2d_defines.svh]
// Assertion macros for the point-to-plane projection RTL.
// No dependencies; included by the top level, which carries the assertions.
`ifndef POINT_PLANE_PROJECTION_2D_DEFINES_SVH
`define POINT_PLANE_PROJECTION_2D_DEFINES_SVH
`ifndef ASSERT_OFF
`define PPP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: assertion failed");
`define PPP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`else
`define PPP_ASSERT(lbl, prop)
`define PPP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

[rtl/ppp_pkg.sv]
// Widths, constants and pipeline payload types of the point-to-plane projection.
// No dependencies; used by every other file of the block except the defines header.
package ppp_pkg;

    localparam int W      = 32;
    localparam int DIFF_W = W + 1;          // magnitude of a coordinate difference
    localparam int NM_W   = 2 * W;          // numerator magnitude
    localparam int H2_W   = 2 * DIFF_W + 1; // squared length of d
    localparam int S_W    = 2 * W;          // nx^2 + ny^2
    localparam int DVD_W  = 2 * W + 1;      // quotient bits to produce
    localparam int REM_W  = S_W - 1;        // division remainder, always below s
    localparam int RAD_W  = H2_W + 1;       // radicand, even number of bits
    localparam int ROOT_W = RAD_W / 2;
    localparam int SREM_W = ROOT_W + 3;
    localparam int N_DIV  = DVD_W;
    localparam int N_SQRT = ROOT_W;

    typedef struct packed {
        logic         degen;
        logic         sn;
        logic [W-1:0] px;
        logic [W-1:0] py;
    } t_side;

    typedef struct packed {
        logic            vld;
        t_side           side;
        logic [H2_W-1:0] h2;
        logic [S_W-1:0]  s;
        logic [REM_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [DVD_W-1:0] quo;
    } t_div;

    typedef struct packed {
        logic              vld;
        t_side             side;
        logic [RAD_W-1:0]  rad_a;
        logic [RAD_W-1:0]  rad_b;
        logic [SREM_W-1:0] rem_a;
        logic [SREM_W-1:0] rem_b;
        logic [ROOT_W-1:0] root_a;
        logic [ROOT_W-1:0] root_b;
    } t_sqr;

endpackage

[rtl/ppp_in_if.sv]
// Input channel of the projection block: handshake and one point/normal/origin beat.
// Depends on ppp_pkg for the coordinate width.
interface ppp_in_if import ppp_pkg::*;;
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;
    logic signed [W-1:0] normal_x;
    logic signed [W-1:0] normal_y;
    logic signed [W-1:0] normal_z;
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] origin_z;

    modport source (output valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                    origin_x, origin_y, origin_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                  origin_x, origin_y, origin_z, output ready);
endinterface

[rtl/ppp_out_if.sv]
// Output channel of the projection block: handshake and one plane coordinate beat.
// Depends on ppp_pkg for the coordinate width.
interface ppp_out_if import ppp_pkg::*;;
    logic                valid;
    logic                ready;
    logic signed [W-1:0] plane_u;
    logic signed [W-1:0] plane_v;

    modport source (output valid, plane_u, plane_v, input ready);
    modport sink (input valid, plane_u, plane_v, output ready);
endinterface

[rtl/point_plane_projection_2d.sv]
// Point-to-plane 2D projection, top level. From input beat to output beat the data
// passes five arithmetic stages, 65 division cells, one subtract stage, 34 square
// root cells and the output register. Throughput one beat per cycle; the whole chain
// advances together and holds while a finished beat waits at the output.
// Reset (synchronous, active low) clears every stage valid flag; no beat is lost in flight
// other than those discarded by reset.
`include "point_plane_projection_2d_defines.svh"
module point_plane_projection_2d import ppp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppp_in_if.sink    i_in,
    ppp_out_if.source o_out
);
    logic en;

    // Stage 1: differences and magnitudes.
    logic              r1_vld;
    t_side             r1_side;
    logic [DIFF_W-1:0] r1_dx, r1_dy, r1_dz;
    logic              r1_sx, r1_sy;
    logic [W-1:0]      r1_nx, r1_ny;
    logic              r1_snx, r1_sny;
    logic signed [DIFF_W-1:0] n_dx, n_dy, n_dz;

    // Stage 2: products.
    logic                  r2_vld;
    t_side                 r2_side;
    logic [2*DIFF_W-1:0]   r2_dx2, r2_dy2, r2_dz2;
    logic [NM_W-1:0]       r2_p, r2_q, r2_nx2, r2_ny2;
    logic                  r2_sp, r2_s2;

    // Stage 3: sums.
    logic            r3_vld;
    t_side           r3_side;
    logic [H2_W-1:0] r3_h2;
    logic [NM_W-1:0] r3_nm;
    logic [S_W-1:0]  r3_s;
    logic [NM_W-1:0] n_nm;
    logic            n_sn;

    // Stage 4: partial products of the numerator square.
    logic            r4_vld;
    t_side           r4_side;
    logic [H2_W-1:0] r4_h2;
    logic [S_W-1:0]  r4_s;
    logic [NM_W-1:0] r4_hh, r4_hl, r4_ll;
    logic [2*NM_W-1:0] n_sq;

    t_div r5;
    t_div div_c [N_DIV+1];
    t_sqr sqr_c [N_SQRT+1];
    t_sqr r6;
    t_div dlast;
    logic [H2_W-1:0] n_rv;

    logic         r_o_vld;
    logic [W-1:0] r_u, r_v;
    logic         r_o_degen;
    logic [W-1:0] n_u, n_v;
    t_sqr         sl;

    assign en         = !r_o_vld || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        n_dx = $signed({i_in.point_x[W-1], i_in.point_x}) -
               $signed({i_in.origin_x[W-1], i_in.origin_x});
        n_dy = $signed({i_in.point_y[W-1], i_in.point_y}) -
               $signed({i_in.origin_y[W-1], i_in.origin_y});
        n_dz = $signed({i_in.point_z[W-1], i_in.point_z}) -
               $signed({i_in.origin_z[W-1], i_in.origin_z});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side.degen <= (i_in.normal_x == '0) && (i_in.normal_y == '0);
            r1_side.sn    <= 1'b0;
            r1_side.px    <= i_in.point_x;
            r1_side.py    <= i_in.point_y;
            r1_sx  <= n_dx[DIFF_W-1];
            r1_sy  <= n_dy[DIFF_W-1];
            r1_dx  <= n_dx[DIFF_W-1] ? DIFF_W'(-n_dx) : DIFF_W'(n_dx);
            r1_dy  <= n_dy[DIFF_W-1] ? DIFF_W'(-n_dy) : DIFF_W'(n_dy);
            r1_dz  <= n_dz[DIFF_W-1] ? DIFF_W'(-n_dz) : DIFF_W'(n_dz);
            r1_snx <= i_in.normal_x[W-1];
            r1_sny <= i_in.normal_y[W-1];
            r1_nx  <= i_in.normal_x[W-1] ? W'(-i_in.normal_x) : i_in.normal_x;
            r1_ny  <= i_in.normal_y[W-1] ? W'(-i_in.normal_y) : i_in.normal_y;

            r2_side <= r1_side;
            r2_dx2  <= r1_dx * r1_dx;
            r2_dy2  <= r1_dy * r1_dy;
            r2_dz2  <= r1_dz * r1_dz;
            r2_p    <= NM_W'(r1_dx * {1'b0, r1_ny});
            r2_q    <= NM_W'(r1_dy * {1'b0, r1_nx});
            r2_nx2  <= r1_nx * r1_nx;
            r2_ny2  <= r1_ny * r1_ny;
            r2_sp   <= r1_sx ^ r1_sny;
            r2_s2   <= !(r1_sy ^ r1_snx);

            r3_side <= {r2_side.degen, n_sn, r2_side.px, r2_side.py};
            r3_h2 <= H2_W'(r2_dx2) + H2_W'(r2_dy2) + H2_W'(r2_dz2);
            r3_nm <= n_nm;
            r3_s  <= r2_nx2 + r2_ny2;

            r4_side <= r3_side;
            r4_h2   <= r3_h2;
            r4_s    <= r3_s;
            r4_hh   <= r3_nm[NM_W-1:W] * r3_nm[NM_W-1:W];
            r4_hl   <= r3_nm[NM_W-1:W] * r3_nm[W-1:0];
            r4_ll   <= r3_nm[W-1:0] * r3_nm[W-1:0];
        end
    end

    // Signed numerator dx*ny - dy*nx as sign and magnitude.
    always_comb begin
        if (r2_sp == r2_s2) begin
            n_nm = r2_p + r2_q;
            n_sn = r2_sp;
        end else if (r2_q <= r2_p) begin
            n_nm = r2_p - r2_q;
            n_sn = r2_sp;
        end else begin
            n_nm = r2_q - r2_p;
            n_sn = r2_s2;
        end
    end

    // Stage 5: full square, and the division starts with the bits above the quotient.
    always_comb begin
        n_sq = {r4_hh, r4_ll} + ((2*NM_W)'(r4_hl) << (W + 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5.vld <= 1'b0;
        end else if (en) begin
            r5.vld  <= r4_vld;
            r5.side <= r4_side;
            r5.h2   <= r4_h2;
            r5.s    <= r4_s;
            r5.rem  <= n_sq[2*NM_W-1:DVD_W];
            r5.dvd  <= n_sq[DVD_W-1:0];
            r5.quo  <= '0;
        end
    end

    assign div_c[0] = r5;

    for (genvar g = 0; g < N_DIV; g++) begin : g_div
        ppp_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_d    (div_c[g]),
            .o_d    (div_c[g+1])
        );
    end

    assign dlast = div_c[N_DIV];

    // Remaining squared length, clamped at zero.
    always_comb begin
        n_rv = (H2_W'(dlast.quo) <= dlast.h2) ? dlast.h2 - H2_W'(dlast.quo) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6.vld <= 1'b0;
        end else if (en) begin
            r6.vld    <= dlast.vld;
            r6.side   <= dlast.side;
            r6.rad_a  <= RAD_W'(dlast.quo);
            r6.rad_b  <= RAD_W'(n_rv);
            r6.rem_a  <= '0;
            r6.rem_b  <= '0;
            r6.root_a <= '0;
            r6.root_b <= '0;
        end
    end

    assign sqr_c[0] = r6;

    for (genvar g = 0; g < N_SQRT; g++) begin : g_sqrt
        ppp_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_d    (sqr_c[g]),
            .o_d    (sqr_c[g+1])
        );
    end

    assign sl = sqr_c[N_SQRT];

    // Saturation to the signed field range.
    always_comb begin
        if (sl.side.sn) begin
            n_u = (sl.root_a > ROOT_W'({1'b1, {(W-1){1'b0}}})) ?
                  {1'b1, {(W-1){1'b0}}} : W'(-sl.root_a);
        end else begin
            n_u = (sl.root_a > ROOT_W'({1'b0, {(W-1){1'b1}}})) ?
                  {1'b0, {(W-1){1'b1}}} : sl.root_a[W-1:0];
        end
        n_v = (sl.root_b > ROOT_W'({1'b0, {(W-1){1'b1}}})) ?
              {1'b0, {(W-1){1'b1}}} : sl.root_b[W-1:0];
        if (sl.side.degen) begin
            n_u = sl.side.px;
            n_v = sl.side.py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld   <= sl.vld;
            r_u       <= n_u;
            r_v       <= n_v;
            r_o_degen <= sl.side.degen;
        end
    end

    assign o_out.valid   = r_o_vld;
    assign o_out.plane_u = r_u;
    assign o_out.plane_v = r_v;

    `PPP_ASSERT_IMPL(a_div_rem_below_s, dlast.vld && !dlast.side.degen, S_W'(dlast.rem) < dlast.s)
    `PPP_ASSERT_IMPL(a_sqrt_rem_bound, sl.vld, sl.rem_a <= SREM_W'({sl.root_a, 1'b0}))
    `PPP_ASSERT_IMPL(a_v_nonneg, r_o_vld && !r_o_degen, !r_v[W-1])
    `PPP_ASSERT_IMPL(a_stall_holds, $past(r_o_vld && !o_out.ready), $stable(r_u) && r_o_vld)
endmodule

[rtl/ppp_div_cell.sv]
// One restoring division step: a single quotient bit per cell, registered.
// Depends on ppp_pkg.
module ppp_div_cell import ppp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);
    logic [S_W-1:0] trial;
    logic           ge;
    t_div           n_d;
    t_div           r_d;

    always_comb begin
        trial = {i_d.rem, i_d.dvd[DVD_W-1]};
        ge    = (trial >= i_d.s);
        n_d   = i_d;
        // When the step fails the trial is below s, so its top bit is clear.
        n_d.rem = ge ? REM_W'(trial - i_d.s) : trial[REM_W-1:0];
        n_d.dvd = {i_d.dvd[DVD_W-2:0], 1'b0};
        n_d.quo = {i_d.quo[DVD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

[rtl/ppp_sqrt_cell.sv]
// One digit step of two integer square roots side by side, registered.
// Depends on ppp_pkg.
module ppp_sqrt_cell import ppp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_sqr i_d,
    output t_sqr o_d
);
    logic [SREM_W-1:0] sh_a, sh_b, tr_a, tr_b;
    logic              ge_a, ge_b;
    t_sqr              n_d;
    t_sqr              r_d;

    always_comb begin
        sh_a = {i_d.rem_a[SREM_W-3:0], i_d.rad_a[RAD_W-1:RAD_W-2]};
        sh_b = {i_d.rem_b[SREM_W-3:0], i_d.rad_b[RAD_W-1:RAD_W-2]};
        tr_a = SREM_W'({i_d.root_a, 2'b01});
        tr_b = SREM_W'({i_d.root_b, 2'b01});
        ge_a = (sh_a >= tr_a);
        ge_b = (sh_b >= tr_b);
        n_d        = i_d;
        n_d.rad_a  = {i_d.rad_a[RAD_W-3:0], 2'b00};
        n_d.rad_b  = {i_d.rad_b[RAD_W-3:0], 2'b00};
        n_d.rem_a  = ge_a ? sh_a - tr_a : sh_a;
        n_d.rem_b  = ge_b ? sh_b - tr_b : sh_b;
        n_d.root_a = {i_d.root_a[ROOT_W-2:0], ge_a};
        n_d.root_b = {i_d.root_b[ROOT_W-2:0], ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

[tb/ppp_checker.sv]
// Checker for the point-to-plane projection: watches both channels, predicts each
// result from the accepted input beats and compares. Depends on ppp_pkg, ppp_in_if, ppp_out_if.
`timescale 1ns / 100ps
module ppp_checker import ppp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ppp_in_if    i_in,
    ppp_out_if   i_out,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic [W-1:0] u;
        logic [W-1:0] v;
    } t_plane;

    t_plane plane_q[$];
    int     errors = 0;

    assign o_errors  = errors;
    assign o_pending = plane_q.size();

    function automatic logic [63:0] int_sqrt(logic [255:0] x);
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [255:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            sq    = 256'(trial) * 256'(trial);
            if (sq <= x) root = trial;
        end
        return root;
    endfunction

    function automatic t_plane project(
        logic signed [W-1:0] px, logic signed [W-1:0] py, logic signed [W-1:0] pz,
        logic signed [W-1:0] nx, logic signed [W-1:0] ny,
        logic signed [W-1:0] ox, logic signed [W-1:0] oy, logic signed [W-1:0] oz);
        logic signed [W:0]   dx, dy, dz;
        logic signed [127:0] num, len2, nsq;
        logic [255:0]        nmag, dist2, norm2, a2, rest;
        logic [63:0]         adj, opp;
        t_plane              res;
        if (nx == 0 && ny == 0) begin
            res.u = px;
            res.v = py;
            return res;
        end
        dx   = {px[W-1], px} - {ox[W-1], ox};
        dy   = {py[W-1], py} - {oy[W-1], oy};
        dz   = {pz[W-1], pz} - {oz[W-1], oz};
        len2 = dx * dx + dy * dy + dz * dz;
        if (len2 == 0) begin
            res.u = '0;
            res.v = '0;
            return res;
        end
        num   = dx * ny - dy * nx;
        nsq   = nx * nx + ny * ny;
        nmag  = (num < 0) ? 256'(-num) : 256'(num);
        dist2 = 256'(len2);
        norm2 = 256'(nsq);
        // Squared component along the in-plane direction, rounded down.
        a2    = (nmag * nmag) / norm2;
        adj   = int_sqrt(a2);
        rest  = (a2 <= dist2) ? dist2 - a2 : '0;
        opp   = int_sqrt(rest);
        if (num < 0)
            res.u = (adj > 64'h8000_0000) ? 32'h8000_0000 : 32'(-adj);
        else
            res.u = (adj > 64'h7fff_ffff) ? 32'h7fff_ffff : adj[W-1:0];
        res.v = (opp > 64'h7fff_ffff) ? 32'h7fff_ffff : opp[W-1:0];
        return res;
    endfunction

    task automatic report(string what, logic [W-1:0] want, logic [W-1:0] got);
        $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_plane want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready)
                plane_q.push_back(project(i_in.point_x, i_in.point_y, i_in.point_z,
                                          i_in.normal_x, i_in.normal_y,
                                          i_in.origin_x, i_in.origin_y, i_in.origin_z));
            if (i_out.valid && i_out.ready) begin
                if (plane_q.size() == 0) begin
                    $display("unexpected beat at %0t: u %h v %h", $realtime,
                             i_out.plane_u, i_out.plane_v);
                    errors++;
                end else begin
                    want = plane_q.pop_front();
                    if (i_out.plane_u !== want.u) report("plane_u", want.u, i_out.plane_u);
                    if (i_out.plane_v !== want.v) report("plane_v", want.v, i_out.plane_v);
                end
            end
        end
    end

endmodule

[tb/testbench.sv]
// Top of the projection testbench: clock, reset, input beats and output stalls, verdict.
// Depends on ppp_pkg, both channel interfaces, ppp_checker and the block itself.
`timescale 1ns / 100ps
module testbench;
    import ppp_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [W-1:0] MAXV = 32'h7fff_ffff;
    localparam logic [W-1:0] MINV = 32'h8000_0000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   cycles  = 0;
    int   beats   = 0;
    bit   burst   = 0;

    ppp_in_if  in_ch ();
    ppp_out_if out_ch ();

    point_plane_projection_2d dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch),
                                   .o_out(out_ch));
    ppp_checker u_checker (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
                           .o_errors(errors), .o_pending(pending));

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.point_x  = '0;
        in_ch.point_y  = '0;
        in_ch.point_z  = '0;
        in_ch.normal_x = '0;
        in_ch.normal_y = '0;
        in_ch.normal_z = '0;
        in_ch.origin_x = '0;
        in_ch.origin_y = '0;
        in_ch.origin_z = '0;
        out_ch.ready   = 1'b0;
    end

    // Receiver: random stalls per beat, one long hold-off to fill the pipeline.
    initial begin
        int  stall;
        bit  held;
        held = 0;
        repeat (11) @(negedge i_clk);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 18);
            if (beats == 60 && !held) begin
                stall = 400;
                held  = 1;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            beats++;
            @(negedge i_clk);
        end
    end

    // Offers one beat at a falling edge and returns at the falling edge after acceptance.
    task automatic send_point(logic [W-1:0] px, logic [W-1:0] py, logic [W-1:0] pz,
                              logic [W-1:0] nx, logic [W-1:0] ny, logic [W-1:0] nz,
                              logic [W-1:0] ox, logic [W-1:0] oy, logic [W-1:0] oz);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.point_x  <= px;
        in_ch.point_y  <= py;
        in_ch.point_z  <= pz;
        in_ch.normal_x <= nx;
        in_ch.normal_y <= ny;
        in_ch.normal_z <= nz;
        in_ch.origin_x <= ox;
        in_ch.origin_y <= oy;
        in_ch.origin_z <= oz;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
    endtask

    // Mostly modest coordinates, with full-range values and the limits mixed in.
    function automatic logic [W-1:0] draw_coord();
        case ($urandom_range(0, 9))
            0:       return MAXV;
            1:       return MINV;
            2, 3, 4: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    initial begin
        logic [W-1:0] px, py, pz, nx, ny, ox, oy, oz;
        int           kind;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: degenerate normal, point on origin, limits and saturation.
        send_point('0, '0, '0, '0, '0, '0, '0, '0, '0);
        send_point(MAXV, MINV, 32'h1234_5678, '0, '0, MAXV, 5, 6, 7);
        send_point(MINV, MAXV, '0, '0, '0, MINV, MAXV, MINV, 3);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, '0, '0,
                   32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_point(MAXV, MAXV, MAXV, MAXV, MINV, '0, MAXV, MAXV, MAXV);
        send_point(MAXV, MAXV, MAXV, '0, 32'h0001_0000, '0, MINV, MINV, MINV);
        send_point(MINV, MAXV, MINV, '0, 32'h0001_0000, '0, MAXV, MINV, MAXV);
        send_point(MAXV, '0, '0, 32'h0000_0001, '0, '0, MINV, '0, '0);
        send_point(MAXV, '0, '0, MINV, '0, '0, MINV, '0, '0);
        send_point('0, MAXV, '0, MAXV, '0, '0, '0, MINV, '0);
        send_point('0, MINV, '0, MAXV, '0, '0, '0, MAXV, '0);
        send_point(MAXV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MAXV, MINV);
        send_point(MINV, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV);
        send_point(32'h0003_0000, 32'h0004_0000, '0, 32'h0000_0001, 32'h0000_0001, '0,
                   '0, '0, '0);
        send_point('0, '0, 32'h0005_0000, 32'hffff_ffff, 32'h0000_0001, '0, '0, '0, '0);
        send_point(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, MAXV,
                   32'hffff_ffff, '0, '0, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 19);
            px = draw_coord(); py = draw_coord(); pz = draw_coord();
            nx = draw_coord(); ny = draw_coord();
            ox = draw_coord(); oy = draw_coord(); oz = draw_coord();
            if (kind < 2) begin
                nx = '0;
                ny = '0;
            end else if (kind == 2) begin
                ox = px; oy = py; oz = pz;
            end else if (kind == 3) begin
                nx = (kind[0]) ? '0 : nx;
                ny = '0;
            end else if (kind == 4) begin
                nx = '0;
            end
            send_point(px, py, pz, nx, ny, $urandom(), ox, oy, oz);
        end
        burst = 0;
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ppp_pkg.sv
rtl/ppp_in_if.sv
rtl/ppp_out_if.sv
rtl/ppp_div_cell.sv
rtl/ppp_sqrt_cell.sv
rtl/point_plane_projection_2d.sv
tb/ppp_checker.sv
tb/testbench.sv
